/* hw/rtl/vms_pkg.sv */
// Types and constants shared by the plane von Mises stress pipeline.
// No dependencies.
`default_nettype none
package vms_pkg;

  localparam int DIV_STEPS  = 32;   // quotient bits of the density divide
  localparam int SQRT_STEPS = 33;   // root bits of the square root
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int LATENCY    = 6 + DIV_STEPS + 3 + SQRT_STEPS + 1;

  // pushed-forward stress is clamped to this magnitude
  localparam logic signed [43:0] SIG_LIM = 44'sh7FF_FFFF_FFFF;

  typedef struct packed {
    logic        [15:0] particle_tag;
    logic signed [15:0] grad_xx;
    logic signed [15:0] grad_xy;
    logic signed [15:0] grad_yx;
    logic signed [15:0] grad_yy;
    logic signed [31:0] pk_xx;
    logic signed [31:0] pk_xy;
    logic signed [31:0] pk_yx;
    logic signed [31:0] pk_yy;
    logic        [19:0] ref_density;
    logic        [19:0] cur_density;
  } vms_in_t;

  typedef struct packed {
    logic [15:0] tag_out;
    logic [31:0] equiv_stress;
    logic        bad_density;
    logic        clipped;
  } vms_res_t;

  // fields that ride along with every beat
  typedef struct packed {
    logic [15:0] tag;
    logic        bad;
    logic        clip;
  } vms_side_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [19:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
  } vms_div_lane_t;

  typedef struct packed {
    vms_side_t                 side;
    logic [19:0]               ref_den;
    vms_div_lane_t [2:0]       lane;   // 0: sxx, 1: syy, 2: sxy
  } vms_div_beat_t;

  typedef struct packed {
    vms_side_t                 side;
    logic [RAD_W-1:0]          rad;
    logic [SQRT_STEPS+1:0]     rem;
    logic [SQRT_STEPS-1:0]     root;
  } vms_sqrt_beat_t;

endpackage
`default_nettype wire

/* hw/rtl/vms_front.sv */
// Front stages: F*S*F^T with rounding, clamp, density product and divide setup.
// Depends on vms_pkg.
`default_nettype none
module vms_front import vms_pkg::*; #(
  parameter int GRAD_FRAC_BITS = 12
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire vms_in_t item_i,
  output logic          valid_o,
  output vms_div_beat_t beat_o
);

  localparam int MW = 50 - GRAD_FRAC_BITS;   // width of F*S entries
  localparam int PW = MW + 16;
  localparam int SW = MW + 17;
  localparam logic signed [48:0] HALF_A = 49'sd1 <<< (GRAD_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HALF_B = SW'(1) <<< (GRAD_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] LIM_W = SW'(SIG_LIM);

  logic [5:0] v_q;

  // stage A
  logic signed [47:0] pa_q [8];
  vms_in_t            ia_q;
  // stage B
  logic signed [MW-1:0] m_q [4];
  vms_in_t              ib_q;
  // stage C
  logic signed [PW-1:0] pc_q [6];
  vms_in_t              ic_q;
  // stage D
  logic [42:0] mag_q [3];
  logic [2:0]  neg_d_q;
  logic        clip_d_q;
  vms_in_t     id_q;
  // stage E
  logic [51:0] plo_q [3];
  logic [30:0] phi_q [3];
  logic [2:0]  neg_e_q;
  logic        clip_e_q;
  vms_in_t     ie_q;
  // stage F
  vms_div_beat_t beat_q;

  logic signed [48:0] sa [4];
  logic signed [48:0] ra [4];
  logic signed [SW-1:0] sb [3];
  logic signed [SW-1:0] rb [3];
  logic signed [SW-1:0] cb [3];
  logic signed [SW-1:0] ab [3];
  logic [2:0] clip_b;
  logic [63:0] n_f [3];
  vms_div_beat_t beat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_comb begin
    sa[0] = 49'(pa_q[0]) + 49'(pa_q[1]);
    sa[1] = 49'(pa_q[2]) + 49'(pa_q[3]);
    sa[2] = 49'(pa_q[4]) + 49'(pa_q[5]);
    sa[3] = 49'(pa_q[6]) + 49'(pa_q[7]);
    for (int k = 0; k < 4; k++) begin
      // round to nearest, ties away from zero
      ra[k] = (sa[k] >= 0) ? ((sa[k] + HALF_A) >>> GRAD_FRAC_BITS)
                           : ((sa[k] + HALF_A - 49'sd1) >>> GRAD_FRAC_BITS);
    end
    sb[0] = SW'(pc_q[0]) + SW'(pc_q[1]);
    sb[1] = SW'(pc_q[2]) + SW'(pc_q[3]);
    sb[2] = SW'(pc_q[4]) + SW'(pc_q[5]);
    for (int k = 0; k < 3; k++) begin
      rb[k] = (sb[k] >= 0) ? ((sb[k] + HALF_B) >>> GRAD_FRAC_BITS)
                           : ((sb[k] + HALF_B - SW'(1)) >>> GRAD_FRAC_BITS);
      clip_b[k] = 1'b0;
      cb[k] = rb[k];
      if (rb[k] > LIM_W) begin
        cb[k] = LIM_W;
        clip_b[k] = 1'b1;
      end else if (rb[k] < -LIM_W) begin
        cb[k] = -LIM_W;
        clip_b[k] = 1'b1;
      end
      ab[k] = (cb[k] < 0) ? -cb[k] : cb[k];
    end
    beat_d.side.tag  = ie_q.particle_tag;
    beat_d.side.bad  = (ie_q.ref_density == '0);
    beat_d.side.clip = clip_e_q;
    beat_d.ref_den   = ie_q.ref_density;
    for (int k = 0; k < 3; k++) begin
      n_f[k] = {1'b0, phi_q[k], 32'd0} + 64'(plo_q[k]) + 64'(ie_q.ref_density[19:1]);
      beat_d.lane[k].neg = neg_e_q[k];
      beat_d.lane[k].ovf = (n_f[k][63:32] >= 32'(ie_q.ref_density));
      beat_d.lane[k].rem = n_f[k][51:32];
      beat_d.lane[k].num = n_f[k][31:0];
      beat_d.lane[k].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q[0] <= item_i.grad_xx * item_i.pk_xx;
    pa_q[1] <= item_i.grad_xy * item_i.pk_yx;
    pa_q[2] <= item_i.grad_xx * item_i.pk_xy;
    pa_q[3] <= item_i.grad_xy * item_i.pk_yy;
    pa_q[4] <= item_i.grad_yx * item_i.pk_xx;
    pa_q[5] <= item_i.grad_yy * item_i.pk_yx;
    pa_q[6] <= item_i.grad_yx * item_i.pk_xy;
    pa_q[7] <= item_i.grad_yy * item_i.pk_yy;
    ia_q    <= item_i;

    for (int k = 0; k < 4; k++) m_q[k] <= MW'(ra[k]);
    ib_q <= ia_q;

    pc_q[0] <= m_q[0] * ib_q.grad_xx;
    pc_q[1] <= m_q[1] * ib_q.grad_xy;
    pc_q[2] <= m_q[2] * ib_q.grad_yx;
    pc_q[3] <= m_q[3] * ib_q.grad_yy;
    pc_q[4] <= m_q[0] * ib_q.grad_yx;
    pc_q[5] <= m_q[1] * ib_q.grad_yy;
    ic_q    <= ib_q;

    for (int k = 0; k < 3; k++) begin
      mag_q[k]   <= ab[k][42:0];
      neg_d_q[k] <= cb[k][SW-1];
    end
    clip_d_q <= |clip_b;
    id_q     <= ic_q;

    for (int k = 0; k < 3; k++) begin
      plo_q[k] <= mag_q[k][31:0] * id_q.cur_density;
      phi_q[k] <= mag_q[k][42:32] * id_q.cur_density;
    end
    neg_e_q  <= neg_d_q;
    clip_e_q <= clip_d_q;
    ie_q     <= id_q;

    beat_q <= beat_d;
  end

  assign valid_o = v_q[5];
  assign beat_o  = beat_q;

endmodule
`default_nettype wire

/* hw/rtl/vms_div_cell.sv */
// One restoring divide step for the three stress lanes: one quotient bit per cell.
// Depends on vms_pkg.
`default_nettype none
module vms_div_cell import vms_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire vms_div_beat_t beat_i,
  output logic               valid_o,
  output vms_div_beat_t      beat_o
);

  logic          valid_q;
  vms_div_beat_t beat_q;
  vms_div_beat_t beat_d;
  logic [20:0]   trial [3];

  always_comb begin
    beat_d = beat_i;
    for (int k = 0; k < 3; k++) begin
      trial[k] = {beat_i.lane[k].rem, beat_i.lane[k].num[31]};
      beat_d.lane[k].num = {beat_i.lane[k].num[30:0], 1'b0};
      if (trial[k] >= {1'b0, beat_i.ref_den}) begin
        beat_d.lane[k].rem = 20'(trial[k] - {1'b0, beat_i.ref_den});
        beat_d.lane[k].quo = {beat_i.lane[k].quo[30:0], 1'b1};
      end else begin
        beat_d.lane[k].rem = trial[k][19:0];
        beat_d.lane[k].quo = {beat_i.lane[k].quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule
`default_nettype wire

/* hw/rtl/vms_quad.sv */
// Saturate the scaled stresses, then form sxx^2 + syy^2 - sxx*syy + 3*sxy^2.
// Depends on vms_pkg.
`default_nettype none
module vms_quad import vms_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire vms_div_beat_t beat_i,
  output logic               valid_o,
  output vms_sqrt_beat_t     beat_o
);

  logic [2:0] v_q;

  logic signed [31:0] s_q [3];
  vms_side_t          side1_q;
  logic signed [63:0] aa_q, bb_q, ab_q, cc_q;
  vms_side_t          side2_q;
  vms_sqrt_beat_t     beat_q;

  logic signed [31:0] s_d [3];
  logic [2:0]         clip_d;
  logic signed [66:0] qsum;
  vms_side_t          side_d;
  vms_sqrt_beat_t     beat_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clip_d[k] = 1'b0;
      if (beat_i.lane[k].ovf) begin
        clip_d[k] = 1'b1;
        s_d[k] = beat_i.lane[k].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (!beat_i.lane[k].neg) begin
        if (beat_i.lane[k].quo[31]) begin
          clip_d[k] = 1'b1;
          s_d[k] = 32'sh7FFF_FFFF;
        end else begin
          s_d[k] = $signed(beat_i.lane[k].quo);
        end
      end else begin
        if (beat_i.lane[k].quo > 32'h8000_0000) begin
          clip_d[k] = 1'b1;
          s_d[k] = 32'sh8000_0000;
        end else begin
          s_d[k] = $signed(-beat_i.lane[k].quo);
        end
      end
    end
    side_d      = beat_i.side;
    side_d.clip = beat_i.side.clip | (|clip_d);

    qsum = 67'(aa_q) + 67'(bb_q) - 67'(ab_q) + 67'(cc_q) + (67'(cc_q) <<< 1);
    beat_d.side = side2_q;
    beat_d.rad  = qsum[RAD_W-1:0];   // form is never negative
    beat_d.rem  = '0;
    beat_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) s_q[k] <= s_d[k];
    side1_q <= side_d;

    aa_q    <= s_q[0] * s_q[0];
    bb_q    <= s_q[1] * s_q[1];
    ab_q    <= s_q[0] * s_q[1];
    cc_q    <= s_q[2] * s_q[2];
    side2_q <= side1_q;

    beat_q <= beat_d;
  end

  assign valid_o = v_q[2];
  assign beat_o  = beat_q;

endmodule
`default_nettype wire

/* hw/rtl/vms_sqrt_cell.sv */
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// Depends on vms_pkg.
`default_nettype none
module vms_sqrt_cell import vms_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire vms_sqrt_beat_t beat_i,
  output logic                valid_o,
  output vms_sqrt_beat_t      beat_o
);

  logic           valid_q;
  vms_sqrt_beat_t beat_q;
  vms_sqrt_beat_t beat_d;
  logic [SQRT_STEPS+3:0] part;
  logic [SQRT_STEPS+3:0] trial;

  always_comb begin
    beat_d     = beat_i;
    part       = {beat_i.rem, beat_i.rad[RAD_W-1:RAD_W-2]};
    trial      = {2'b00, beat_i.root, 2'b01};
    beat_d.rad = {beat_i.rad[RAD_W-3:0], 2'b00};
    if (part >= trial) begin
      beat_d.rem  = (SQRT_STEPS+2)'(part - trial);
      beat_d.root = {beat_i.root[SQRT_STEPS-2:0], 1'b1};
    end else begin
      beat_d.rem  = part[SQRT_STEPS+1:0];
      beat_d.root = {beat_i.root[SQRT_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule
`default_nettype wire

/* hw/rtl/von_mises_stress_2d_core.sv */
// Top level of the plane von Mises stress pipeline.
// Depends on vms_pkg, vms_front, vms_div_cell, vms_quad, vms_sqrt_cell.
//
// Usage:
//   Drive item_i and raise start; the beat is taken at any clock edge where
//   start is high and busy is low. busy stays low, so one particle can be
//   issued every cycle.
//   Each particle gives one result on result_o, marked by valid_o for exactly
//   one cycle. Results leave in issue order.
//   Throughput is one particle per cycle; the pipeline holds the 32 divide cells
//   of the density scaling and the 33 root cells, plus 10 arithmetic stages.
//   Zero reference density gives equiv_stress 0 and bad_density set.
//   Reset (rst_ni low) clears all stage valids; beats in flight are dropped.
//   The receiver cannot stall; results must be taken when valid_o is high.
`default_nettype none
module von_mises_stress_2d_core import vms_pkg::*; #(
  parameter int GRAD_FRAC_BITS = 12
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire vms_in_t item_i,
  output logic         valid_o,
  output vms_res_t     result_o
);

  logic [DIV_STEPS:0]  div_v;
  vms_div_beat_t       div_b [DIV_STEPS+1];
  logic [SQRT_STEPS:0] sq_v;
  vms_sqrt_beat_t      sq_b [SQRT_STEPS+1];

  logic     out_v_q;
  vms_res_t out_q;
  vms_res_t out_d;

  assign busy = 1'b0;

  vms_front #(
    .GRAD_FRAC_BITS(GRAD_FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .valid_i(start & ~busy),
    .item_i,
    .valid_o(div_v[0]),
    .beat_o (div_b[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    vms_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .valid_i(div_v[g]),
      .beat_i (div_b[g]),
      .valid_o(div_v[g+1]),
      .beat_o (div_b[g+1])
    );
  end

  vms_quad u_quad (
    .clk_i,
    .rst_ni,
    .valid_i(div_v[DIV_STEPS]),
    .beat_i (div_b[DIV_STEPS]),
    .valid_o(sq_v[0]),
    .beat_o (sq_b[0])
  );

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    vms_sqrt_cell u_cell (
      .clk_i,
      .rst_ni,
      .valid_i(sq_v[g]),
      .beat_i (sq_b[g]),
      .valid_o(sq_v[g+1]),
      .beat_o (sq_b[g+1])
    );
  end

  always_comb begin
    out_d.tag_out     = sq_b[SQRT_STEPS].side.tag;
    out_d.bad_density = sq_b[SQRT_STEPS].side.bad;
    if (sq_b[SQRT_STEPS].side.bad) begin
      out_d.equiv_stress = '0;
      out_d.clipped      = 1'b0;
    end else if (sq_b[SQRT_STEPS].root[SQRT_STEPS-1]) begin
      out_d.equiv_stress = 32'hFFFF_FFFF;
      out_d.clipped      = 1'b1;
    end else begin
      out_d.equiv_stress = sq_b[SQRT_STEPS].root[31:0];
      out_d.clipped      = sq_b[SQRT_STEPS].side.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o  = out_v_q;
  assign result_o = out_q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY (valid_o &&
      result_o.tag_out == $past(item_i.particle_tag, LATENCY)))
    else $error("result missing or tag mismatch at fixed latency");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.bad_density) |-> (result_o.equiv_stress == '0 &&
      !result_o.clipped))
    else $error("bad density result not forced to zero");

  a_div_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[DIV_STEPS] |-> ##(3 + SQRT_STEPS + 1) valid_o)
    else $error("beat lost between divide and root chains");
`endif

endmodule
`default_nettype wire

/* test/vms_checker.sv */
// Checker for von_mises_stress_2d_core: watches the accepted input beats and the result strobe,
// predicts each result and compares it field by field. Depends on vms_pkg.
`timescale 1ns / 1ps
module vms_checker import vms_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire vms_in_t  item_i,
  input  wire logic     valid_o,
  input  wire vms_res_t result_o,
  output int            fail_count,
  output int            pending
);
  localparam int FRAC = 12;
  localparam longint LIM43 = 64'sh7FF_FFFF_FFFF;

  vms_res_t stress_q[$];

  function automatic longint rnd_shift(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi, inout bit clip);
    if (v > hi) begin
      clip = 1;
      return hi;
    end
    if (v < lo) begin
      clip = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint dens_scale(longint s, longint cur, longint rf, inout bit clip);
    logic [63:0] mag;
    longint v;
    mag = (s < 0) ? -s : s;
    mag = (mag * cur + rf / 2) / rf;
    v = (s < 0) ? -longint'(mag) : longint'(mag);
    return sat(v, -64'sd2147483648, 64'sd2147483647, clip);
  endfunction

  function automatic vms_res_t plane_stress(vms_in_t it);
    vms_res_t r;
    longint f[2][2], s[2][2], m[2][2];
    longint sxx, syy, sxy, rf, cur;
    logic signed [129:0] q;
    logic [65:0] t;
    logic [65:0] root;
    bit clip;
    r = '0;
    clip = 0;
    r.tag_out = it.particle_tag;
    rf = it.ref_density;
    cur = it.cur_density;
    if (rf == 0) begin
      r.bad_density = 1;
      return r;
    end
    f[0][0] = it.grad_xx; f[0][1] = it.grad_xy;
    f[1][0] = it.grad_yx; f[1][1] = it.grad_yy;
    s[0][0] = it.pk_xx; s[0][1] = it.pk_xy;
    s[1][0] = it.pk_yx; s[1][1] = it.pk_yy;
    for (int i = 0; i < 2; i++)
      for (int l = 0; l < 2; l++)
        m[i][l] = rnd_shift(f[i][0] * s[0][l] + f[i][1] * s[1][l]);
    sxx = rnd_shift(m[0][0] * f[0][0] + m[0][1] * f[0][1]);
    syy = rnd_shift(m[1][0] * f[1][0] + m[1][1] * f[1][1]);
    sxy = rnd_shift(m[0][0] * f[1][0] + m[0][1] * f[1][1]);
    sxx = sat(sxx, -LIM43, LIM43, clip);
    syy = sat(syy, -LIM43, LIM43, clip);
    sxy = sat(sxy, -LIM43, LIM43, clip);
    sxx = dens_scale(sxx, cur, rf, clip);
    syy = dens_scale(syy, cur, rf, clip);
    sxy = dens_scale(sxy, cur, rf, clip);
    q = 130'(sxx * sxx) + 130'(syy * syy) + 3 * 130'(sxy * sxy) - 130'(sxx * syy);
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      t = root | (66'd1 << b);
      if ({64'd0, t * t} <= q) root = t;
    end
    if (root > 66'hFFFF_FFFF) begin
      root = 66'hFFFF_FFFF;
      clip = 1;
    end
    r.equiv_stress = root[31:0];
    r.clipped = clip;
    return r;
  endfunction

  assign pending = stress_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vms_res_t want;
    if (!rst_ni) begin
      fail_count <= 0;
      stress_q.delete();
    end else begin
      if (valid_o) begin
        if (stress_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_o);
          fail_count <= fail_count + 1;
        end else begin
          want = stress_q.pop_front();
          if (want.tag_out !== result_o.tag_out || want.equiv_stress !== result_o.equiv_stress ||
              want.bad_density !== result_o.bad_density ||
              want.clipped !== result_o.clipped) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, result_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) stress_q.push_back(plane_stress(item_i));
    end
  end
endmodule

/* test/tb.sv */
// Testbench top for von_mises_stress_2d_core: clock, reset, directed and random particle
// beats, verdict. Depends on vms_pkg, the core and vms_checker.
`timescale 1ns / 1ps
module tb;
  import vms_pkg::*;

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     start = 0;
  logic     busy;
  vms_in_t  item_i = '0;
  logic     valid_o;
  vms_res_t result_o;
  int       fail_count, pending;
  int       cycles = 0;
  bit       calm = 0;

  always #6 clk_i = ~clk_i;

  von_mises_stress_2d_core u_top (.*);
  vms_checker u_chk (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL von_mises_stress_2d_core");
      $finish;
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h1000;
      3: return 16'($signed($urandom_range(0, 16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vms_in_t random_particle();
    vms_in_t it;
    it.particle_tag = 16'($urandom);
    it.grad_xx = pick16(); it.grad_xy = pick16();
    it.grad_yx = pick16(); it.grad_yy = pick16();
    it.pk_xx = pick32(); it.pk_xy = pick32();
    it.pk_yx = pick32(); it.pk_yy = pick32();
    case ($urandom_range(0, 9))
      0: it.ref_density = 0;
      1: it.ref_density = 20'hFFFFF;
      2: it.ref_density = 1;
      default: it.ref_density = 20'($urandom_range(1, 20'hFFFFF));
    endcase
    case ($urandom_range(0, 9))
      0: it.cur_density = 0;
      1: it.cur_density = 20'hFFFFF;
      2: it.cur_density = it.ref_density;
      default: it.cur_density = 20'($urandom);
    endcase
    return it;
  endfunction

  // hold a beat on start until it is taken; start stays high after return, and the next call may drop it unless calm
  task automatic send_particle(vms_in_t it);
    while (!calm && $urandom_range(0, 99) < 38) begin
      start <= 0;
      @(posedge clk_i);
    end
    item_i <= it;
    start <= 1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    vms_in_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: identity, extremes, zero densities, shear only
    it = '0;
    it.grad_xx = 16'h1000; it.grad_yy = 16'h1000;
    it.pk_xx = 32'sd25600; it.pk_yy = -32'sd12800; it.pk_xy = 32'sd5000;
    it.pk_yx = 32'sd7000;
    it.ref_density = 20'd16; it.cur_density = 20'd16;
    send_particle(it);
    it.cur_density = 0;
    send_particle(it);
    it.ref_density = 0; it.cur_density = 20'hFFFFF;
    send_particle(it);
    it = '1;
    send_particle(it);
    it.grad_xx = 16'h8000; it.grad_xy = 16'h8000; it.grad_yx = 16'h8000;
    it.grad_yy = 16'h8000;
    it.pk_xx = 32'h8000_0000; it.pk_xy = 32'h8000_0000;
    it.pk_yx = 32'h8000_0000; it.pk_yy = 32'h8000_0000;
    it.ref_density = 1; it.cur_density = 20'hFFFFF;
    send_particle(it);
    it.grad_xx = 16'h7FFF; it.grad_yy = 16'h7FFF; it.pk_xx = 32'h7FFF_FFFF;
    it.pk_yy = 32'h7FFF_FFFF; it.particle_tag = 0;
    send_particle(it);
    it = '0;
    it.grad_xx = 16'h1000; it.grad_yy = 16'h1000; it.pk_xy = 32'sd1000;
    it.pk_yx = -32'sd9999; it.ref_density = 20'hFFFFF; it.cur_density = 20'd1;
    send_particle(it);
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 400 && n < 550);
      if (n == 700) begin
        start <= 0;
        while (pending != 0) @(posedge clk_i);
      end
      send_particle(random_particle());
    end
    start <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) $display("PASS von_mises_stress_2d_core");
    else $display("FAIL von_mises_stress_2d_core");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/vms_pkg.sv
hw/rtl/vms_front.sv
hw/rtl/vms_div_cell.sv
hw/rtl/vms_quad.sv
hw/rtl/vms_sqrt_cell.sv
hw/rtl/von_mises_stress_2d_core.sv
test/vms_checker.sv
test/tb.sv
